// ===== rtl/core/modbus_rtu_read_response_checker_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef MODBUS_RTU_READ_RESPONSE_CHECKER_MACROS_SVH
`define MODBUS_RTU_READ_RESPONSE_CHECKER_MACROS_SVH

// same-cycle implication, held off during reset
`define MRRC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, held off during reset
`define MRRC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/mrrc_pkg.sv =====
package mrrc_pkg;

    localparam int OP_W       = 2;
    localparam int COUNT_W    = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_COUNT  = 1'b1;

    localparam logic [7:0]         SLAVE_ADDR_RST = 8'd1;
    localparam logic [COUNT_W-1:0] EXP_COUNT_RST  = 6'd4;

    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [7:0]  EXC_MASK       = 8'h80;
    localparam logic [7:0]  FUNC_READ_HOLD = 8'h03;

    typedef enum logic [OP_W-1:0] {
        OP_DATA    = 2'd0,
        OP_START   = 2'd1,
        OP_TIMEOUT = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_ADDR    = 3'd1,
        STS_EXC     = 3'd2,
        STS_EXC_CRC = 3'd3,
        STS_FUNC    = 3'd4,
        STS_COUNT   = 3'd5,
        STS_CRC     = 3'd6,
        STS_TRUNC   = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEADER,
        S_BODY,
        S_CRC,
        S_EXC,
        S_RD,
        S_WR
    } t_state;

    typedef struct packed {
        logic    load_in;
        logic    frame_start;
        logic    crc_upd;
        logic    pend_ld;
        logic    func_ld;
        logic    crc_low_ld;
        logic    idx_clr;
        logic    idx_inc;
        logic    mem_wr;
        logic    emit_clr;
        logic    emit_inc;
        logic    mem_rd;
        logic    out_load;
        logic    out_from_mem;
        logic    out_exc;
        t_status out_status;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic idx_is0;
        logic idx_is1;
        logic idx_odd;
        logic addr_ok;
        logic func_exc;
        logic func_ok;
        logic count_ok;
        logic body_done;
        logic crc_ok;
        logic n_zero;
        logic burst_done;
    } t_sts;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/mrrc_datapath.sv =====
module mrrc_datapath
    import mrrc_pkg::*;
#(
    parameter int MAX_REGS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [OP_W-1:0]       i_op,
    input  logic [7:0]            i_data_byte,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic [15:0]           o_reg_word,
    output logic [2:0]            o_status,
    output logic [7:0]            o_exception_code,
    output logic                  o_last
);

    localparam int AW    = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
    localparam int CW    = $clog2(MAX_REGS + 1);
    localparam int CMP_W = ((CW > COUNT_W) ? CW : COUNT_W) + 1;

    logic [7:0]         r_slave_addr;
    logic [COUNT_W-1:0] r_exp_count;

    t_op                r_op;
    logic [7:0]         r_byte;
    logic [7:0]         r_idx;
    logic [15:0]        r_crc;
    logic [7:0]         r_func;
    logic [7:0]         r_crc_low;
    logic [7:0]         r_pend;
    logic [CW-1:0]      r_emit;

    logic [15:0]        r_reg_store [MAX_REGS];
    logic [15:0]        r_rd_data;

    logic [15:0]        r_out_word;
    t_status            r_out_status;
    logic [7:0]         r_out_exc;
    logic               r_out_last;

    logic [AW-1:0]      w_wr_addr;
    logic               w_wr_in_range;
    logic [CMP_W-1:0]   w_n_ext;
    logic [CMP_W-1:0]   w_max_ext;
    logic [CMP_W-1:0]   w_emit_next;
    logic               w_last_word;
    logic [7:0]         w_idx_next;
    logic [7:0]         w_byte_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= SLAVE_ADDR_RST;
            r_exp_count  <= EXP_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SLAVE_ADDR: r_slave_addr <= i_cfg_data;
                REG_EXP_COUNT:  r_exp_count  <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_emit <= '0;
        end else begin
            if (i_cmd.frame_start || i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= w_idx_next;
            end
            if (i_cmd.emit_clr) begin
                r_emit <= '0;
            end else if (i_cmd.emit_inc) begin
                r_emit <= r_emit + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op   <= t_op'(i_op);
            r_byte <= i_data_byte;
        end
        if (i_cmd.frame_start) begin
            r_crc <= CRC_INIT;
        end else if (i_cmd.crc_upd) begin
            r_crc <= crc_update(r_crc, r_byte);
        end
        if (i_cmd.pend_ld) begin
            r_pend <= r_byte;
        end
        if (i_cmd.func_ld) begin
            r_func <= r_byte;
        end
        if (i_cmd.crc_low_ld) begin
            r_crc_low <= r_byte;
        end
    end

    // word store: one write port, one registered read port
    assign w_wr_addr     = AW'(r_idx[7:1]);
    assign w_wr_in_range = ({1'b0, r_idx[7:1]} < 8'(MAX_REGS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr && w_wr_in_range) begin
            r_reg_store[w_wr_addr] <= {r_pend, r_byte};
        end
        if (i_cmd.mem_rd) begin
            r_rd_data <= r_reg_store[r_emit[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.out_from_mem) begin
                r_out_word   <= r_rd_data;
                r_out_status <= STS_OK;
                r_out_exc    <= '0;
                r_out_last   <= w_last_word;
            end else begin
                r_out_word   <= '0;
                r_out_status <= i_cmd.out_status;
                r_out_exc    <= i_cmd.out_exc ? r_pend : 8'd0;
                r_out_last   <= 1'b1;
            end
        end
    end

    assign w_n_ext      = CMP_W'(r_exp_count);
    assign w_max_ext    = CMP_W'(MAX_REGS);
    assign w_emit_next  = CMP_W'(r_emit) + CMP_W'(1);
    assign w_last_word  = (w_emit_next == w_n_ext);
    assign w_idx_next   = r_idx + 8'd1;
    assign w_byte_count = 8'({r_exp_count, 1'b0});

    always_comb begin
        o_sts.op         = r_op;
        o_sts.idx_is0    = (r_idx == 8'd0);
        o_sts.idx_is1    = (r_idx == 8'd1);
        o_sts.idx_odd    = r_idx[0];
        o_sts.addr_ok    = (r_pend == r_slave_addr);
        o_sts.func_exc   = ((r_func & EXC_MASK) != 8'd0);
        o_sts.func_ok    = (r_func == FUNC_READ_HOLD);
        o_sts.count_ok   = (r_exp_count != '0) && (w_n_ext <= w_max_ext)
                           && (r_byte == w_byte_count);
        o_sts.body_done  = (w_idx_next >= w_byte_count);
        o_sts.crc_ok     = ({r_byte, r_crc_low} == r_crc);
        o_sts.n_zero     = (r_exp_count == '0);
        o_sts.burst_done = (w_emit_next >= w_n_ext) || (w_emit_next >= w_max_ext);
    end

    assign o_reg_word       = r_out_word;
    assign o_status         = r_out_status;
    assign o_exception_code = r_out_exc;
    assign o_last           = r_out_last;

endmodule

// ===== rtl/core/mrrc_ctrl.sv =====
module mrrc_ctrl
    import mrrc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_in_full, n_in_full;
    logic   r_out_valid, n_out_valid;
    logic   w_consume;
    logic   w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_full   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_full   <= n_in_full;
            r_out_valid <= n_out_valid;
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd            = '0;
        o_cmd.out_status = STS_OK;
        n_state          = r_state;
        w_consume        = 1'b0;

        o_cmd.load_in = i_in_valid && !r_in_full;

        case (r_state)
            S_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_WR;
            end
            S_WR: begin
                if (w_out_free) begin
                    o_cmd.out_load     = 1'b1;
                    o_cmd.out_from_mem = 1'b1;
                    o_cmd.emit_inc     = 1'b1;
                    n_state            = i_sts.burst_done ? S_IDLE : S_RD;
                end
            end
            default: begin
                if (r_in_full) begin
                    case (i_sts.op)
                        OP_START: begin
                            w_consume         = 1'b1;
                            o_cmd.frame_start = 1'b1;
                            n_state           = S_HEADER;
                        end
                        OP_TIMEOUT: begin
                            if (r_state == S_IDLE) begin
                                w_consume = 1'b1;
                            end else if (w_out_free) begin
                                w_consume        = 1'b1;
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_status = STS_TRUNC;
                                n_state          = S_IDLE;
                            end
                        end
                        OP_DATA: begin
                            case (r_state)
                                S_HEADER: begin
                                    if (i_sts.idx_is0 || i_sts.idx_is1) begin
                                        w_consume     = 1'b1;
                                        o_cmd.crc_upd = 1'b1;
                                        o_cmd.idx_inc = 1'b1;
                                        o_cmd.pend_ld = i_sts.idx_is0;
                                        o_cmd.func_ld = i_sts.idx_is1;
                                    end else if (i_sts.addr_ok && i_sts.func_exc) begin
                                        w_consume     = 1'b1;
                                        o_cmd.crc_upd = 1'b1;
                                        o_cmd.pend_ld = 1'b1;
                                        o_cmd.idx_clr = 1'b1;
                                        n_state       = S_EXC;
                                    end else if (i_sts.addr_ok && i_sts.func_ok
                                                 && i_sts.count_ok) begin
                                        w_consume     = 1'b1;
                                        o_cmd.crc_upd = 1'b1;
                                        o_cmd.idx_clr = 1'b1;
                                        n_state       = S_BODY;
                                    end else if (w_out_free) begin
                                        // header refused: address, then function, then count
                                        w_consume      = 1'b1;
                                        o_cmd.crc_upd  = 1'b1;
                                        o_cmd.out_load = 1'b1;
                                        n_state        = S_IDLE;
                                        if (!i_sts.addr_ok) begin
                                            o_cmd.out_status = STS_ADDR;
                                        end else if (!i_sts.func_ok) begin
                                            o_cmd.out_status = STS_FUNC;
                                        end else begin
                                            o_cmd.out_status = STS_COUNT;
                                        end
                                    end
                                end
                                S_BODY: begin
                                    w_consume     = 1'b1;
                                    o_cmd.crc_upd = 1'b1;
                                    o_cmd.pend_ld = !i_sts.idx_odd;
                                    o_cmd.mem_wr  = i_sts.idx_odd;
                                    if (i_sts.body_done) begin
                                        o_cmd.idx_clr = 1'b1;
                                        n_state       = S_CRC;
                                    end else begin
                                        o_cmd.idx_inc = 1'b1;
                                    end
                                end
                                S_CRC: begin
                                    if (i_sts.idx_is0) begin
                                        w_consume        = 1'b1;
                                        o_cmd.crc_low_ld = 1'b1;
                                        o_cmd.idx_inc    = 1'b1;
                                    end else if (i_sts.crc_ok) begin
                                        w_consume      = 1'b1;
                                        o_cmd.emit_clr = 1'b1;
                                        n_state        = i_sts.n_zero ? S_IDLE : S_RD;
                                    end else if (w_out_free) begin
                                        w_consume        = 1'b1;
                                        o_cmd.out_load   = 1'b1;
                                        o_cmd.out_status = STS_CRC;
                                        n_state          = S_IDLE;
                                    end
                                end
                                S_EXC: begin
                                    if (i_sts.idx_is0) begin
                                        w_consume        = 1'b1;
                                        o_cmd.crc_low_ld = 1'b1;
                                        o_cmd.idx_inc    = 1'b1;
                                    end else if (w_out_free) begin
                                        w_consume        = 1'b1;
                                        o_cmd.out_load   = 1'b1;
                                        o_cmd.out_exc    = 1'b1;
                                        o_cmd.out_status = i_sts.crc_ok ? STS_EXC
                                                                        : STS_EXC_CRC;
                                        n_state          = S_IDLE;
                                    end
                                end
                                default: begin
                                    w_consume = 1'b1;
                                end
                            endcase
                        end
                        default: begin
                            w_consume = 1'b1;
                        end
                    endcase
                end
            end
        endcase

        n_in_full   = (r_in_full && !w_consume) || o_cmd.load_in;
        n_out_valid = o_cmd.out_load || (r_out_valid && !i_out_ready);
    end

    assign o_in_ready  = !r_in_full;
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/modbus_rtu_read_response_checker.sv =====
// Modbus RTU read-holding-registers reply checker.
// Input channel (i_in_valid / o_in_ready) carries one transaction per received
// event: i_op = data byte, start of reply or reply timeout, with i_data_byte.
// Output channel (o_out_valid / i_out_ready) carries results: register words
// with status ok, or a single status result, the final one flagged by o_last.
// Configuration: i_cfg_we with i_cfg_idx 0 (slave address) or 1 (register
// count) and i_cfg_data, taken on the same edge; the user must write it only
// while no reply is in flight, as the block does not enforce this.
// An input transaction is registered, then run by the header/body/CRC
// controller; no new one is taken until it has run. A status result is
// registered in the output register as its transaction runs. After the
// last CRC byte matches, each word passes a store read, then the output
// register (held while stalled); the store has one registered read port.
// Reset (synchronous, i_rst_n low) returns to idle, empties both channel
// registers and restores the address to 1 and the count to 4.
// When the receiver stalls, the output register holds its result; transactions
// that give no result still pass, and the first one that needs the output waits
// in the input register, which holds the input channel off.
module modbus_rtu_read_response_checker
    import mrrc_pkg::*;
#(
    parameter int MAX_REGS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [OP_W-1:0]       i_op,
    input  logic [7:0]            i_data_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [15:0]           o_reg_word,
    output logic [2:0]            o_status,
    output logic [7:0]            o_exception_code,
    output logic                  o_last
);

    t_cmd w_cmd;
    t_sts w_sts;

    mrrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    mrrc_datapath #(
        .MAX_REGS (MAX_REGS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_op             (i_op),
        .i_data_byte      (i_data_byte),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_reg_word       (o_reg_word),
        .o_status         (o_status),
        .o_exception_code (o_exception_code),
        .o_last           (o_last)
    );

endmodule

// ===== rtl/core/mrrc_checker.sv =====
`include "modbus_rtu_read_response_checker_macros.svh"

module mrrc_checker
    import mrrc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_reg_word,
    input logic [2:0]  o_status,
    input logic [7:0]  o_exception_code,
    input logic        o_last
);

    `MRRC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_reg_word) && $stable(o_status) && $stable(o_exception_code) && $stable(o_last), "output changed while stalled")

    `MRRC_ASSERT_NOW(a_fail_last, o_out_valid && (o_status != STS_OK), o_last, "status result without last mark")

    `MRRC_ASSERT_NOW(a_fail_word, o_out_valid && (o_status != STS_OK), o_reg_word == 16'd0, "status result carries a word")

    `MRRC_ASSERT_NOW(a_exc_code, o_out_valid && (o_status != STS_EXC) && (o_status != STS_EXC_CRC), o_exception_code == 8'd0, "exception code outside an exception reply")

    `MRRC_ASSERT_NEXT(a_one_in_flight, i_in_valid && o_in_ready, !o_in_ready, "second transaction taken before the first ran")

endmodule

bind modbus_rtu_read_response_checker mrrc_checker u_mrrc_checker (.*);
